>>> sv/sha1_block_compression_macros.svh
// Assertion macros shared by the SHA-1 block compression RTL.
`ifndef SHA1_BLOCK_COMPRESSION_MACROS_SVH
`define SHA1_BLOCK_COMPRESSION_MACROS_SVH

`ifndef ASSERT_OFF
// Check cons in the same cycle whenever ante holds.
`define SHA1BC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1bc assertion failed");
// Check cons in the cycle after ante holds.
`define SHA1BC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1bc assertion failed");
`else
`define SHA1BC_ASSERT_IMPLY(lbl, ante, cons)
`define SHA1BC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/sha1bc_pkg.sv
// Types, constants and helper functions of the SHA-1 block compression engine.
package sha1bc_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int SHA1_ROUNDS  = 80;
    localparam int ROUND_W      = 7;
    localparam int DIG_IDX_W    = 3;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } work_t;

    localparam word_t SHA1_IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    function automatic word_t rotl1(input word_t v);
        return {v[30:0], v[31]};
    endfunction

    function automatic word_t rotl5(input word_t v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

>>> sv/sha1bc_sched_ram.sv
// Message schedule memory: one write port, two registered read ports.
module sha1bc_sched_ram
    import sha1bc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  word_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output word_t                    rdata_a,
    output word_t                    rdata_b
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> sv/sha1bc_chain_ram.sv
// Chaining word memory: one write port, one registered read port.
module sha1bc_chain_ram
    import sha1bc_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [DIG_IDX_W-1:0] waddr,
    input  word_t                wdata,
    input  logic [DIG_IDX_W-1:0] raddr,
    output word_t                rdata
);

    word_t mem [DIGEST_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/sha1bc_round.sv
// One SHA-1 round: select f and K by round number and advance the working words.
module sha1bc_round
    import sha1bc_pkg::*;
(
    input  logic [ROUND_W-1:0] round,
    input  work_t              cur,
    input  word_t              w,
    output work_t              nxt
);

    word_t f;
    word_t k;

    always_comb
    begin
        if (round < ROUND_W'(20))
        begin
            f = cur.d ^ (cur.b & (cur.c ^ cur.d));
            k = K_00_19;
        end
        else if (round < ROUND_W'(40))
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_20_39;
        end
        else if (round < ROUND_W'(60))
        begin
            f = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
            k = K_40_59;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_60_79;
        end
        nxt.a = rotl5(cur.a) + f + cur.e + w + k;
        nxt.b = cur.a;
        nxt.c = rotl30(cur.b);
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

>>> sv/sha1_block_compression.sv
// Top level of the SHA-1 block compression engine: sequencer and datapath.
//
// Feed a padded message one big-endian 32-bit word per request, sixteen
// requests per 512-bit block. Set first_block on word 0 to start a new
// message from the SHA-1 initial values, and final_block on word 15 to get
// the digest of the message once that block is compressed. Words are taken
// one per cycle while a block is being collected; after word 15 msg_ready
// drops while the working words load from the chaining memory, the 80 rounds
// run and the result is added back into the chaining memory, and on a final
// block until the digest is out. A priming state issues the first schedule
// reads, then each round passes through S_RD2 and S_ROUND, because its four
// schedule words come out of a two-read-port schedule memory with registered
// reads. A final block then emits five digest requests, H0 first, each read
// from the chaining memory, registered and held until digest_ready, with
// digest_last high on the fifth. No clearing pass runs after reset: a single
// flag marks the chaining memory as unwritten, and until then the initial
// values stand in for its contents.
`include "sha1_block_compression_macros.svh"

module sha1_block_compression
    import sha1bc_pkg::*;
#(
    parameter int BLOCK_WORDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_ready,
    input  logic [31:0]          message_word,
    input  logic                 first_block,
    input  logic                 final_block,
    output logic                 digest_valid,
    input  logic                 digest_ready,
    output logic [31:0]          digest_word,
    output logic [DIG_IDX_W-1:0] digest_index,
    output logic                 digest_last
);

    localparam int POS_W = $clog2(BLOCK_WORDS);

    typedef enum logic [3:0] {
        S_LOAD,
        S_HREAD,
        S_HLOAD,
        S_RD1,
        S_RD2,
        S_ROUND,
        S_ADD_RD,
        S_ADD,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 restart_reg, restart_next;
    logic                 final_reg, final_next;
    logic                 chain_valid_reg, chain_valid_next;
    logic [DIG_IDX_W-1:0] cnt_reg, cnt_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    work_t                work_reg, work_next;
    word_t                partial_reg, partial_next;
    logic                 dvalid_reg, dvalid_next;
    word_t                dword_reg, dword_next;
    logic [DIG_IDX_W-1:0] didx_reg, didx_next;
    logic                 dlast_reg, dlast_next;

    logic                 sched_we;
    logic [POS_W-1:0]     sched_waddr;
    word_t                sched_wdata;
    logic [POS_W-1:0]     sched_raddr_a;
    logic [POS_W-1:0]     sched_raddr_b;
    word_t                sched_q_a;
    word_t                sched_q_b;

    logic                 chain_we;
    logic [DIG_IDX_W-1:0] chain_waddr;
    word_t                chain_wdata;
    logic [DIG_IDX_W-1:0] chain_raddr;
    word_t                chain_q;

    logic                 msg_take;
    logic                 use_init;
    logic                 cnt_last;
    logic [DIG_IDX_W-1:0] cnt_succ;
    logic [ROUND_W-1:0]   round_succ;
    logic [POS_W-1:0]     slot;
    logic [POS_W-1:0]     slot_succ;
    word_t                chain_base;
    word_t                sched_w;
    work_t                round_out;

    sha1bc_sched_ram #(
        .DEPTH(BLOCK_WORDS)
    ) u_sched_ram (
        .clk    (clk),
        .we     (sched_we),
        .waddr  (sched_waddr),
        .wdata  (sched_wdata),
        .raddr_a(sched_raddr_a),
        .raddr_b(sched_raddr_b),
        .rdata_a(sched_q_a),
        .rdata_b(sched_q_b)
    );

    sha1bc_chain_ram u_chain_ram (
        .clk  (clk),
        .we   (chain_we),
        .waddr(chain_waddr),
        .wdata(chain_wdata),
        .raddr(chain_raddr),
        .rdata(chain_q)
    );

    sha1bc_round u_round (
        .round(round_reg),
        .cur  (work_reg),
        .w    (sched_w),
        .nxt  (round_out)
    );

    assign msg_ready    = (state_reg == S_LOAD);
    assign msg_take     = msg_valid && msg_ready;
    assign digest_valid = dvalid_reg;
    assign digest_word  = dword_reg;
    assign digest_index = didx_reg;
    assign digest_last  = dlast_reg;

    // Until the first write-back the chaining memory holds nothing; use the IV.
    assign use_init   = restart_reg || !chain_valid_reg;
    assign cnt_last   = (cnt_reg == DIG_IDX_W'(DIGEST_WORDS - 1));
    assign cnt_succ   = cnt_last ? '0 : cnt_reg + 1'b1;
    assign round_succ = round_reg + 1'b1;
    assign slot       = round_reg[POS_W-1:0];
    assign slot_succ  = round_succ[POS_W-1:0];
    assign chain_base = use_init ? SHA1_IV[cnt_reg] : chain_q;

    // Rounds below sixteen use the stored message word; later ones expand it.
    assign sched_w = (round_reg < ROUND_W'(BLOCK_WORDS)) ? sched_q_b
                   : rotl1(partial_reg ^ sched_q_a ^ sched_q_b);

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        restart_next     = restart_reg;
        final_next       = final_reg;
        chain_valid_next = chain_valid_reg;
        cnt_next         = cnt_reg;
        round_next       = round_reg;
        work_next        = work_reg;
        partial_next     = partial_reg;
        dvalid_next      = dvalid_reg;
        dword_next       = dword_reg;
        didx_next        = didx_reg;
        dlast_next       = dlast_reg;

        sched_we      = 1'b0;
        sched_waddr   = pos_reg;
        sched_wdata   = message_word;
        sched_raddr_a = slot;
        sched_raddr_b = slot;

        chain_we    = 1'b0;
        chain_waddr = cnt_reg;
        chain_wdata = chain_base + work_reg.a;
        chain_raddr = cnt_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (msg_take)
                begin
                    sched_we = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == '0)
                    begin
                        restart_next = first_block;
                    end
                    if (pos_reg == POS_W'(BLOCK_WORDS - 1))
                    begin
                        final_next = final_block;
                        cnt_next   = '0;
                        state_next = S_HREAD;
                    end
                end
            end
            S_HREAD:
            begin
                chain_raddr = '0;
                state_next  = S_HLOAD;
            end
            S_HLOAD:
            begin
                // Shift chaining words in at e so that H0 ends up in a.
                work_next   = {work_reg.b, work_reg.c, work_reg.d, work_reg.e, chain_base};
                chain_raddr = cnt_succ;
                cnt_next    = cnt_succ;
                if (cnt_last)
                begin
                    round_next = '0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                sched_raddr_a = slot - POS_W'(3);
                sched_raddr_b = slot - POS_W'(8);
                state_next    = S_RD2;
            end
            S_RD2:
            begin
                partial_next  = sched_q_a ^ sched_q_b;
                sched_raddr_a = slot - POS_W'(14);
                sched_raddr_b = slot;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                work_next = round_out;
                if (round_reg >= ROUND_W'(BLOCK_WORDS))
                begin
                    sched_we    = 1'b1;
                    sched_waddr = slot;
                    sched_wdata = sched_w;
                end
                // Issue the first read pair of the next round.
                sched_raddr_a = slot_succ - POS_W'(3);
                sched_raddr_b = slot_succ - POS_W'(8);
                if (round_reg == ROUND_W'(SHA1_ROUNDS - 1))
                begin
                    state_next = S_ADD_RD;
                end
                else
                begin
                    round_next = round_succ;
                    state_next = S_RD2;
                end
            end
            S_ADD_RD:
            begin
                chain_raddr = '0;
                cnt_next    = '0;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                chain_we    = 1'b1;
                work_next   = {work_reg.b, work_reg.c, work_reg.d, work_reg.e, work_reg.a};
                chain_raddr = cnt_succ;
                cnt_next    = cnt_succ;
                if (cnt_last)
                begin
                    chain_valid_next = 1'b1;
                    restart_next     = 1'b0;
                    state_next       = final_reg ? S_EMIT_RD : S_LOAD;
                end
            end
            S_EMIT_RD:
            begin
                chain_raddr = cnt_reg;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                dvalid_next = 1'b1;
                dword_next  = chain_q;
                didx_next   = cnt_reg;
                dlast_next  = cnt_last;
                state_next  = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (digest_ready)
                begin
                    dvalid_next = 1'b0;
                    cnt_next    = cnt_succ;
                    state_next  = cnt_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            pos_reg         <= '0;
            restart_reg     <= 1'b0;
            final_reg       <= 1'b0;
            chain_valid_reg <= 1'b0;
            cnt_reg         <= '0;
            round_reg       <= '0;
            dvalid_reg      <= 1'b0;
            dword_reg       <= '0;
            didx_reg        <= '0;
            dlast_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            restart_reg     <= restart_next;
            final_reg       <= final_next;
            chain_valid_reg <= chain_valid_next;
            cnt_reg         <= cnt_next;
            round_reg       <= round_next;
            dvalid_reg      <= dvalid_next;
            dword_reg       <= dword_next;
            didx_reg        <= didx_next;
            dlast_reg       <= dlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        partial_reg <= partial_next;
    end

    `SHA1BC_ASSERT_IMPLY(a_no_take_during_digest, msg_ready, !digest_valid)
    `SHA1BC_ASSERT_IMPLY(a_sched_no_rw_clash, sched_we && (state_reg == S_ROUND),
        (sched_waddr != sched_raddr_a) && (sched_waddr != sched_raddr_b))
    `SHA1BC_ASSERT_IMPLY(a_chain_no_rw_clash, chain_we, chain_waddr != chain_raddr)
    `SHA1BC_ASSERT_NEXT(a_block_end_stalls,
        msg_take && (pos_reg == POS_W'(BLOCK_WORDS - 1)), !msg_ready)
    `SHA1BC_ASSERT_IMPLY(a_digest_index_range, digest_valid,
        digest_index <= DIG_IDX_W'(DIGEST_WORDS - 1))

endmodule

>>> sim/sha1_block_compression_test.sv
// Self-checking testbench for the SHA-1 block compression engine.
`timescale 1ns / 100ps

module sha1_block_compression_test
    import sha1bc_pkg::*;
();

    localparam int BLOCK_LEN    = 16;
    localparam int CLK_HALF_NS  = 4;
    // A non-final block still compresses after its last word, so give any
    // stray digest request time to show up before the end.
    localparam int SETTLE_CYCLES = 250;
    // Watchdog limit, set well above the slowest correct run.
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        word_t                word;
        logic [DIG_IDX_W-1:0] index;
        logic                 last;
    } digest_rec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 msg_valid;
    logic                 msg_ready;
    logic [31:0]          message_word;
    logic                 first_block;
    logic                 final_block;
    logic                 digest_valid;
    logic                 digest_ready;
    logic [31:0]          digest_word;
    logic [DIG_IDX_W-1:0] digest_index;
    logic                 digest_last;

    // Shadow copy of the engine state used to predict each digest.
    word_t       chain_h [DIGEST_WORDS];
    word_t       block_buf [BLOCK_LEN];
    int          word_pos;
    logic        restart_flag;

    // Digest words still owed by the engine, oldest first.
    digest_rec_t digest_q [$];

    int          errors;
    int          words_sent;
    int          msg_idle_pct;
    int          digest_stall_pct;

    sha1_block_compression dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .message_word (message_word),
        .first_block  (first_block),
        .final_block  (final_block),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_last  (digest_last)
    );

    //------------------------------------------------------------------
    // Digest predictor
    //------------------------------------------------------------------

    function automatic word_t rol32(input word_t v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Run the 80 rounds over block_buf and fold the result into chain_h.
    function automatic void compress_block();
        word_t sched [BLOCK_LEN];
        word_t a, b, c, d, e;
        word_t wt, fn, kt, sum;
        for (int i = 0; i < BLOCK_LEN; i++)
            sched[i] = block_buf[i];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < SHA1_ROUNDS; t++)
        begin
            if (t >= BLOCK_LEN)
            begin
                wt = sched[(t - 3) % BLOCK_LEN] ^ sched[(t - 8) % BLOCK_LEN] ^
                     sched[(t - 14) % BLOCK_LEN] ^ sched[t % BLOCK_LEN];
                wt = rol32(wt, 1);
                sched[t % BLOCK_LEN] = wt;
            end
            else
                wt = sched[t];
            if (t < 20)
            begin
                fn = d ^ (b & (c ^ d));
                kt = K_00_19;
            end
            else if (t < 40)
            begin
                fn = b ^ c ^ d;
                kt = K_20_39;
            end
            else if (t < 60)
            begin
                fn = (b & c) | (d & (b | c));
                kt = K_40_59;
            end
            else
            begin
                fn = b ^ c ^ d;
                kt = K_60_79;
            end
            sum = rol32(a, 5) + fn + e + wt + kt;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Absorb one accepted message word; queue the digest on a final block.
    function automatic void absorb_word(input word_t word, input logic first,
                                        input logic final_flag);
        digest_rec_t rec;
        if (word_pos == 0)
            restart_flag = first;
        block_buf[word_pos] = word;
        if (word_pos != BLOCK_LEN - 1)
            word_pos++;
        else
        begin
            word_pos = 0;
            if (restart_flag)
            begin
                for (int k = 0; k < DIGEST_WORDS; k++)
                    chain_h[k] = SHA1_IV[k];
                restart_flag = 1'b0;
            end
            compress_block();
            if (final_flag)
            begin
                for (int k = 0; k < DIGEST_WORDS; k++)
                begin
                    rec.word  = chain_h[k];
                    rec.index = k[DIG_IDX_W-1:0];
                    rec.last  = (k == DIGEST_WORDS - 1);
                    digest_q.push_back(rec);
                end
            end
        end
    endfunction

    //------------------------------------------------------------------
    // Clock, reset and watchdog
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("sha1_block_compression_test failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Digest side: random stalls and result checking
    //------------------------------------------------------------------

    // Drop ready at random on each falling edge, per the current phase.
    initial
    begin
        digest_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            digest_ready <= ($urandom_range(99) >= digest_stall_pct);
        end
    end

    // Compare every accepted digest request with the oldest prediction.
    always @(posedge clk)
    begin : check_digest
        digest_rec_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest request: word %h index %0d last %0b",
                       digest_word, digest_index, digest_last);
                errors++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (digest_word !== want.word)
                begin
                    $error("digest_word mismatch: expected %h, actual %h",
                           want.word, digest_word);
                    errors++;
                end
                if (digest_index !== want.index)
                begin
                    $error("digest_index mismatch: expected %0d, actual %0d",
                           want.index, digest_index);
                    errors++;
                end
                if (digest_last !== want.last)
                begin
                    $error("digest_last mismatch: expected %0b, actual %0b",
                           want.last, digest_last);
                    errors++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Message side
    //------------------------------------------------------------------

    // Present one word request and hold it until the engine takes it. Valid
    // stays high into the next call unless that call decides to idle first.
    task automatic send_word(input word_t word, input logic first,
                             input logic final_flag);
        @(negedge clk);
        while ($urandom_range(99) < msg_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid    <= 1'b1;
        message_word <= word;
        first_block  <= first;
        final_block  <= final_flag;
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        absorb_word(word, first, final_flag);
        words_sent++;
    endtask

    // Hold off the sender until every predicted digest word has arrived.
    task automatic wait_for_digests();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // Bias toward all-zero and all-one words to hit the word extremes often.
    function automatic word_t pick_word();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 32'h0000_0000;
        else if (sel == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Send a message of whole blocks. Most are well formed; the rest skip the
    // restart flag (chain on from the previous state), never finish, or carry
    // flags on positions where the engine must ignore them.
    task automatic send_message();
        int   nblocks;
        int   kind;
        logic with_first;
        logic with_final;
        logic noisy;
        logic f_first;
        logic f_final;
        nblocks    = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
        kind       = $urandom_range(99);
        with_first = (kind >= 10);
        with_final = !(kind >= 10 && kind < 20);
        noisy      = (kind >= 80);
        for (int b = 0; b < nblocks; b++)
        begin
            for (int w = 0; w < BLOCK_LEN; w++)
            begin
                f_first = (w == 0 && b == 0) ? with_first : 1'b0;
                f_final = (w == BLOCK_LEN - 1 && b == nblocks - 1) ? with_final : 1'b0;
                if (noisy && !(w == 0 && b == 0))
                    f_first = 1'($urandom_range(1));
                if (noisy && !(w == BLOCK_LEN - 1 && b == nblocks - 1))
                    f_final = 1'($urandom_range(1));
                send_word(pick_word(), f_first, f_final);
            end
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // One block straight after reset with no restart flag, so chaining must
    // start from the reset values. Flags sit on every position where they
    // must be ignored, and the words cover both extremes.
    task automatic test_first_block_after_reset();
        word_t w;
        msg_idle_pct     = 0;
        digest_stall_pct = 0;
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            if (i == 0)
                w = 32'h6162_6380;
            else if (i == BLOCK_LEN - 1)
                w = 32'h0000_0018;
            else if (i < 8)
                w = 32'hFFFF_FFFF;
            else
                w = 32'h0000_0000;
            send_word(w, i != 0, i != 0 || 1'b0 ? 1'b1 : 1'b1);
        end
    endtask

    // Restart in the middle of a run: the chain has moved on, a new message
    // with the restart flag must reload the initial values.
    task automatic test_restart_after_chain();
        for (int i = 0; i < BLOCK_LEN; i++)
            send_word(32'h8000_0000 >> i, i == 0, i == BLOCK_LEN - 1);
    endtask

    // Random messages until the word budget is spent.
    task automatic test_random_messages(input int budget, input int idle_pct,
                                        input int stall_pct);
        int start;
        msg_idle_pct     = idle_pct;
        digest_stall_pct = stall_pct;
        start            = words_sent;
        while (words_sent - start < budget)
            send_message();
    endtask

    // Pause the sender mid-stream until the engine has delivered everything.
    task automatic test_pause_for_digests();
        wait_for_digests();
        send_message();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial
    begin
        errors           = 0;
        words_sent       = 0;
        msg_idle_pct     = 0;
        digest_stall_pct = 0;
        word_pos         = 0;
        restart_flag     = 1'b0;
        for (int k = 0; k < DIGEST_WORDS; k++)
            chain_h[k] = SHA1_IV[k];
        for (int i = 0; i < BLOCK_LEN; i++)
            block_buf[i] = '0;

        rst_n        = 1'b0;
        msg_valid    = 1'b0;
        message_word = '0;
        first_block  = 1'b0;
        final_block  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_block_after_reset();
        test_restart_after_chain();
        test_random_messages(64, 0, 0);
        test_pause_for_digests();
        test_random_messages(48, 69, 0);
        test_pause_for_digests();
        test_random_messages(64, 0, 69);
        test_pause_for_digests();
        test_random_messages(48, 9, 9);

        // Drain: no more requests, wait for the last digest and then let the
        // engine sit long enough to expose any stray output.
        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("sha1_block_compression_test passed");
        else
            $display("sha1_block_compression_test failed");
        $finish;
    end

endmodule
